[sv/hdw_pkg.sv]
// Package for the 4-bit character LCD writer: request codes, sequence kinds,
// the power-up nibble program and the pin action helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hdw_pkg;

	// request codes carried in the operation field
	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_INIT   = 3'd1,
		OP_CMD    = 3'd2,
		OP_CHAR   = 3'd3,
		OP_CURSOR = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	// kind of sequence that is running
	typedef enum logic [2:0] {
		KIND_NONE  = 3'd0,
		KIND_INIT  = 3'd1,
		KIND_CMD   = 3'd2,
		KIND_CHAR  = 3'd3,
		KIND_CLEAR = 3'd4
	} kind_t;

	localparam int unsigned POWER_UP_WAIT_TICKS_DEF = 50;
	localparam int unsigned WAIT_W                  = 6;
	localparam int unsigned STEP_W                  = 5;
	localparam int unsigned INIT_NIBBLES            = 12;
	localparam logic [STEP_W-1:0] INIT_STEPS = STEP_W'(2 * INIT_NIBBLES);
	localparam logic [STEP_W-1:0] BYTE_STEPS = STEP_W'(4);
	localparam logic [7:0] CMD_CLEAR  = 8'h01;
	localparam logic [7:0] CMD_HOME   = 8'h02;
	localparam logic [5:0] COLUMN_MAX = 6'd39;

	// one pin action: new nibble (when raising), enable level, wait ticks
	typedef struct packed {
		logic              load_nib;
		logic [3:0]        nib;
		logic              en;
		logic [WAIT_W-1:0] wait_cnt;
	} action_t;

	// power-up program nibbles
	function automatic logic [3:0] init_nibble(input logic [3:0] n);
		logic [3:0] r;
		case (n)
			4'd0:    r = 4'h3;
			4'd1:    r = 4'h3;
			4'd2:    r = 4'h3;
			4'd3:    r = 4'h2;
			4'd4:    r = 4'h2;
			4'd5:    r = 4'h8;
			4'd6:    r = 4'h0;
			4'd7:    r = 4'hC;
			4'd8:    r = 4'h0;
			4'd9:    r = 4'h1;
			4'd10:   r = 4'h0;
			default: r = 4'h6;
		endcase
		return r;
	endfunction

	// extra ticks after each power-up nibble
	function automatic logic [2:0] init_extra(input logic [3:0] n);
		logic [2:0] r;
		case (n)
			4'd0:    r = 3'd5;
			4'd1:    r = 3'd1;
			4'd2:    r = 3'd1;
			4'd5:    r = 3'd1;
			4'd7:    r = 3'd1;
			4'd9:    r = 3'd4;
			4'd11:   r = 3'd1;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// pin action for a given step of the running sequence
	function automatic action_t do_action(input logic [STEP_W-1:0] step, input kind_t kind,
			input logic [7:0] latch);
		logic [3:0] n;
		logic [3:0] nib;
		logic [2:0] extra;
		action_t    a;
		n = step[4:1];
		if (n > 4'(INIT_NIBBLES - 1))
			n = 4'(INIT_NIBBLES - 1);
		if (kind == KIND_INIT) begin
			nib   = init_nibble(n);
			extra = init_extra(n);
		end else begin
			nib   = step[1] ? latch[3:0] : latch[7:4];
			extra = 3'd0;
			if (step[1]) begin
				if (kind == KIND_CLEAR)
					extra = 3'd4;
				else if (kind == KIND_CMD && (latch == CMD_CLEAR || latch == CMD_HOME))
					extra = 3'd2;
			end
		end
		if (!step[0]) begin
			a.load_nib = 1'b1;
			a.nib      = nib;
			a.en       = 1'b1;
			a.wait_cnt = WAIT_W'(1);
		end else begin
			a.load_nib = 1'b0;
			a.nib      = nib;
			a.en       = 1'b0;
			a.wait_cnt = WAIT_W'(1) + WAIT_W'(extra);
		end
		return a;
	endfunction

endpackage
`default_nettype wire

[sv/hdw_req_if.sv]
// Request channel of the LCD writer: valid/ready handshake and request payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface hdw_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [7:0] value;
	logic       row;
	logic [5:0] column;

	modport source (output valid, operation, value, row, column, input ready);
	modport sink   (input valid, operation, value, row, column, output ready);
endinterface
`default_nettype wire

[sv/hdw_res_if.sv]
// Result channel of the LCD writer: valid/ready handshake and pin levels.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface hdw_res_if;
	logic       valid;
	logic       ready;
	logic       rs_level;
	logic       enable_level;
	logic [3:0] data_nibble;
	logic       busy_res;
	logic       rejected;

	modport source (output valid, rs_level, enable_level, data_nibble, busy_res, rejected,
		input ready);
	modport sink   (input valid, rs_level, enable_level, data_nibble, busy_res, rejected,
		output ready);
endinterface
`default_nettype wire

[sv/hd44780_4bit_writer.sv]
// Top level of the 4-bit character LCD writer: sequencer state and result register.
// Depends on hdw_pkg, hdw_req_if and hdw_res_if.
// The result of an accepted request is registered in the output register.
// Throughput: one request per cycle while not stalled; state updates on acceptance.
// Ready stays high while the output register is empty or is being drained.
// Reset clears the sequencer to idle with all pins low and the output register empty.
`timescale 1ns / 1ps
`default_nettype none
module hd44780_4bit_writer #(
	parameter int unsigned POWER_UP_WAIT_TICKS = hdw_pkg::POWER_UP_WAIT_TICKS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	hdw_req_if.sink     req,
	hdw_res_if.source   res
);
	import hdw_pkg::*;

	localparam logic [WAIT_W-1:0] POWER_UP_WAIT = WAIT_W'(POWER_UP_WAIT_TICKS);

	// sequencer state
	logic [STEP_W-1:0] step_q;
	logic [WAIT_W-1:0] wait_q;
	logic [7:0]        latch_q;
	kind_t             kind_q;
	logic              rs_q;
	logic              en_q;
	logic [3:0]        nib_q;

	logic [STEP_W-1:0] step_d;
	logic [WAIT_W-1:0] wait_d;
	logic [7:0]        latch_d;
	kind_t             kind_d;
	logic              rs_d;
	logic              en_d;
	logic [3:0]        nib_d;
	logic              rej_d;

	logic              busy;
	logic [WAIT_W-1:0] wait_dec;
	logic [STEP_W-1:0] seq_len;
	logic [5:0]        col_sat;
	action_t           act;

	// output register
	logic       out_valid_q;
	logic       out_rs_q;
	logic       out_en_q;
	logic [3:0] out_nib_q;
	logic       out_busy_q;
	logic       out_rej_q;

	logic accept;

	assign req.ready = !out_valid_q || res.ready;
	assign accept    = req.valid && req.ready;

	assign busy     = (kind_q != KIND_NONE);
	assign wait_dec = (wait_q != '0) ? wait_q - WAIT_W'(1) : '0;
	assign seq_len  = (kind_q == KIND_INIT) ? INIT_STEPS : BYTE_STEPS;
	assign col_sat  = (req.column > COLUMN_MAX) ? COLUMN_MAX : req.column;
	assign act      = do_action(step_q, kind_q, latch_q);

	// next state for the request at the input
	always_comb begin
		step_d  = step_q;
		wait_d  = wait_q;
		latch_d = latch_q;
		kind_d  = kind_q;
		rs_d    = rs_q;
		en_d    = en_q;
		nib_d   = nib_q;
		rej_d   = 1'b0;
		case (op_t'(req.operation))
			OP_TICK: begin
				if (busy) begin
					wait_d = wait_dec;
					if (wait_dec == '0) begin
						if (step_q < seq_len) begin
							en_d   = act.en;
							wait_d = act.wait_cnt;
							if (act.load_nib)
								nib_d = act.nib;
							step_d = step_q + STEP_W'(1);
						end else begin
							kind_d = KIND_NONE;
							step_d = '0;
						end
					end
				end
			end
			OP_INIT: begin
				if (busy) begin
					rej_d = 1'b1;
				end else begin
					kind_d = KIND_INIT;
					rs_d   = 1'b0;
					step_d = '0;
					wait_d = POWER_UP_WAIT;
				end
			end
			OP_CMD, OP_CHAR, OP_CURSOR, OP_CLEAR: begin
				if (busy) begin
					rej_d = 1'b1;
				end else begin
					case (op_t'(req.operation))
						OP_CMD: begin
							kind_d  = KIND_CMD;
							latch_d = req.value;
							rs_d    = 1'b0;
						end
						OP_CHAR: begin
							kind_d  = KIND_CHAR;
							latch_d = req.value;
							rs_d    = 1'b1;
						end
						OP_CURSOR: begin
							kind_d  = KIND_CMD;
							latch_d = {1'b1, req.row, col_sat};
							rs_d    = 1'b0;
						end
						default: begin
							kind_d  = KIND_CLEAR;
							latch_d = CMD_CLEAR;
							rs_d    = 1'b0;
						end
					endcase
					// first action: high nibble out, enable raised
					nib_d  = latch_d[7:4];
					en_d   = 1'b1;
					wait_d = WAIT_W'(1);
					step_d = STEP_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			wait_q  <= '0;
			latch_q <= '0;
			kind_q  <= KIND_NONE;
			rs_q    <= 1'b0;
			en_q    <= 1'b0;
			nib_q   <= '0;
		end else if (accept) begin
			step_q  <= step_d;
			wait_q  <= wait_d;
			latch_q <= latch_d;
			kind_q  <= kind_d;
			rs_q    <= rs_d;
			en_q    <= en_d;
			nib_q   <= nib_d;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_rs_q   <= rs_d;
			out_en_q   <= en_d;
			out_nib_q  <= nib_d;
			out_busy_q <= (kind_d != KIND_NONE);
			out_rej_q  <= rej_d;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.rs_level     = out_rs_q;
	assign res.enable_level = out_en_q;
	assign res.data_nibble  = out_nib_q;
	assign res.busy_res     = out_busy_q;
	assign res.rejected     = out_rej_q;

endmodule
`default_nettype wire

[sv/hdw_chk.sv]
// Port-level checker for the LCD writer, bound to the top level.
// Depends on hd44780_4bit_writer and its request and result interfaces.
`timescale 1ns / 1ps
`default_nettype none
module hdw_chk (
	input wire       clk,
	input wire       arst_n,
	input wire       req_valid,
	input wire       req_ready,
	input wire       res_valid,
	input wire       res_ready,
	input wire       res_enable_level,
	input wire       res_busy_res,
	input wire       res_rejected
);

	// a refused request never changes state, so the block is still busy
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_rejected |-> res_busy_res)
		else $error("rejected request reported while not busy");

	// enable is only high inside a running sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_enable_level |-> res_busy_res)
		else $error("enable high while idle");

	// an empty output register never stalls the request side
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> req_ready)
		else $error("request stalled with empty output");

	// a stalled result is not dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// every accepted request produces a result on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> res_valid)
		else $error("accepted request produced no result");

endmodule

bind hd44780_4bit_writer hdw_chk u_hdw_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_enable_level (res.enable_level),
	.res_busy_res     (res.busy_res),
	.res_rejected     (res.rejected)
);
`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the 4-bit character LCD writer: directed and random requests
// and ticks, with pin levels predicted by a scoreboard class and compared per result.
// Depends on hdw_pkg, hdw_req_if, hdw_res_if and hd44780_4bit_writer.
`timescale 1ns / 1ps
module testbench;
	import hdw_pkg::*;

	localparam logic [2:0] OP_SPARE6   = 3'd6;
	localparam logic [2:0] OP_SPARE7   = 3'd7;
	localparam logic [7:0] DISP_CLEAR  = 8'h01;
	localparam logic [7:0] LCD_HOME    = 8'h02;
	localparam logic [7:0] ROW0_BASE   = 8'h80;
	localparam logic [7:0] ROW1_BASE   = 8'hC0;
	localparam logic [5:0] COL_LIMIT   = 6'd39;
	localparam logic [4:0] PWR_STEPS   = 5'd24;
	localparam logic [4:0] BYTE_ACTS   = 5'd4;
	// power-up nibbles and their extra ticks, entry n at bits [4n+3:4n]
	localparam logic [47:0] PWR_NIBBLES = 48'h6010_C082_2333;
	localparam logic [47:0] PWR_EXTRAS  = 48'h1040_1010_0115;
	localparam int unsigned LIMIT_CYCLES = 300000;

	typedef struct packed {
		logic       rs;
		logic       en;
		logic [3:0] nib;
		logic       busy;
		logic       rej;
	} pins_t;

	// tracks the sequencer and holds the pin levels still to come
	class pin_level_tracker;
		logic [4:0]  step;
		logic [5:0]  wait_left;
		logic [7:0]  latch;
		kind_t       running;
		logic        rs;
		logic        en;
		logic [3:0]  nib;
		pins_t       pending_pins[$];
		int unsigned mismatches;

		function new();
			step       = '0;
			wait_left  = '0;
			latch      = '0;
			running    = KIND_NONE;
			rs         = 1'b0;
			en         = 1'b0;
			nib        = '0;
			mismatches = 0;
		endfunction

		function bit is_busy();
			return running != KIND_NONE;
		endfunction

		// one pin action: raise with a new nibble, or lower and hold
		function void apply_action(logic [4:0] s);
			int unsigned n;
			int unsigned extra;
			logic [3:0]  pick;
			n     = s >> 1;
			extra = 0;
			if (running == KIND_INIT) begin
				if (n > 11)
					n = 11;
				pick  = PWR_NIBBLES[4*n +: 4];
				extra = PWR_EXTRAS[4*n +: 4];
			end else begin
				pick = (n == 0) ? latch[7:4] : latch[3:0];
				if (n == 1) begin
					if (running == KIND_CLEAR)
						extra = 4;
					else if (running == KIND_CMD && (latch == DISP_CLEAR || latch == LCD_HOME))
						extra = 2;
				end
			end
			if (!s[0]) begin
				nib       = pick;
				en        = 1'b1;
				wait_left = 6'd1;
			end else begin
				en        = 1'b0;
				wait_left = 6'(1 + extra);
			end
		endfunction

		function void start_byte(kind_t k, logic [7:0] b, logic rs_pin);
			running = k;
			latch   = b;
			rs      = rs_pin;
			apply_action(5'd0);
			step = 5'd1;
		endfunction

		// predict the pin levels after one accepted request
		function void note_request(logic [2:0] op, logic [7:0] v, logic r, logic [5:0] c);
			logic       rej;
			logic [5:0] col;
			pins_t      p;
			rej = 1'b0;
			if (op == OP_TICK) begin
				if (is_busy()) begin
					if (wait_left > 0)
						wait_left = wait_left - 6'd1;
					if (wait_left == 0) begin
						if (step < ((running == KIND_INIT) ? PWR_STEPS : BYTE_ACTS)) begin
							apply_action(step);
							step = step + 5'd1;
						end else begin
							running = KIND_NONE;
							step    = '0;
						end
					end
				end
			end else if (op <= OP_CLEAR) begin
				if (is_busy()) begin
					rej = 1'b1;
				end else begin
					case (op)
						OP_INIT: begin
							running   = KIND_INIT;
							rs        = 1'b0;
							step      = '0;
							wait_left = 6'(POWER_UP_WAIT_TICKS_DEF);
						end
						OP_CMD:  start_byte(KIND_CMD, v, 1'b0);
						OP_CHAR: start_byte(KIND_CHAR, v, 1'b1);
						OP_CURSOR: begin
							col = (c > COL_LIMIT) ? COL_LIMIT : c;
							start_byte(KIND_CMD, (r ? ROW1_BASE : ROW0_BASE) + {2'b00, col}, 1'b0);
						end
						default: start_byte(KIND_CLEAR, DISP_CLEAR, 1'b0);
					endcase
				end
			end
			p.rs   = rs;
			p.en   = en;
			p.nib  = nib;
			p.busy = is_busy();
			p.rej  = rej;
			pending_pins.push_back(p);
		endfunction

		function void compare_pin(string pin, logic [3:0] want, logic [3:0] got);
			if (want !== got) begin
				mismatches++;
				$display("%0t: %s expected %h got %h", $time, pin, want, got);
			end
		endfunction

		// compare one result with the oldest prediction
		function void check_pins(pins_t got);
			pins_t want;
			if (pending_pins.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result expected none got %h", $time, got);
				return;
			end
			want = pending_pins.pop_front();
			compare_pin("rs_level", {3'b0, want.rs}, {3'b0, got.rs});
			compare_pin("enable_level", {3'b0, want.en}, {3'b0, got.en});
			compare_pin("data_nibble", want.nib, got.nib);
			compare_pin("busy_res", {3'b0, want.busy}, {3'b0, got.busy});
			compare_pin("rejected", {3'b0, want.rej}, {3'b0, got.rej});
		endfunction
	endclass

	bit          clk;
	logic        arst_n;
	int unsigned cycles;
	int unsigned send_idle_pct;
	int unsigned take_stall_pct;
	pin_level_tracker sb;

	hdw_req_if req_ch ();
	hdw_res_if res_ch ();

	hd44780_4bit_writer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.res    (res_ch.source)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side back-pressure
	always @(negedge clk)
		res_ch.ready <= ($urandom_range(99) >= take_stall_pct);

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_pins({res_ch.rs_level, res_ch.enable_level, res_ch.data_nibble,
				res_ch.busy_res, res_ch.rejected});
	end

	// drive one request, leaving valid high after acceptance
	task automatic send_request(input logic [2:0] op, input logic [7:0] v, input logic r,
			input logic [5:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.value     <= v;
		req_ch.row       <= r;
		req_ch.column    <= c;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.note_request(op, v, r, c);
		@(negedge clk);
	endtask

	// ticks with junk in the unused fields until the sequence is done
	task automatic tick_until_idle();
		while (sb.is_busy())
			send_request(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
				6'($urandom_range(63)));
	endtask

	task automatic run_request(input logic [2:0] op, input logic [7:0] v, input logic r,
			input logic [5:0] c);
		send_request(op, v, r, c);
		tick_until_idle();
	endtask

	// mostly well-paced sequences, with rejected and spare requests mixed in
	task automatic random_traffic(input int unsigned budget);
		int unsigned counted;
		int unsigned pick;
		logic [2:0]  op;
		logic [7:0]  v;
		counted = 0;
		while (counted < budget) begin
			pick = $urandom_range(99);
			if (sb.is_busy()) begin
				if (pick < 88)
					op = OP_TICK;
				else
					op = 3'($urandom_range(7, 1));
			end else begin
				if (pick < 8)
					op = OP_TICK;
				else if (pick < 12)
					op = 3'($urandom_range(7, 6));
				else if (pick < 15)
					op = OP_INIT;
				else
					op = 3'($urandom_range(5, 2));
			end
			v = 8'($urandom_range(255));
			if (op == OP_CMD && $urandom_range(4) == 0)
				v = $urandom_range(1) ? DISP_CLEAR : LCD_HOME;
			// idle ticks and spare codes do nothing and are not counted
			if (!(op > OP_CLEAR || (op == OP_TICK && !sb.is_busy())))
				counted++;
			send_request(op, v, 1'($urandom_range(1)), 6'($urandom_range(63)));
		end
	endtask

	// reset, stimulus and final verdict
	initial begin
		arst_n           = 1'b0;
		cycles           = 0;
		send_idle_pct    = 17;
		take_stall_pct   = 68;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_TICK;
		req_ch.value     = '0;
		req_ch.row       = 1'b0;
		req_ch.column    = '0;
		res_ch.ready     = 1'b0;
		sb = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// idle tick and spare codes
		send_request(OP_TICK, 8'hFF, 1'b1, 6'd63);
		send_request(OP_SPARE6, 8'hFF, 1'b1, 6'd63);
		send_request(OP_SPARE7, 8'h00, 1'b0, 6'd0);
		// power-up program, with a request refused while it runs
		send_request(OP_INIT, 8'h00, 1'b0, 6'd0);
		send_request(OP_CHAR, 8'h41, 1'b0, 6'd0);
		tick_until_idle();
		// commands with and without extra waits
		send_request(OP_CMD, DISP_CLEAR, 1'b0, 6'd0);
		send_request(OP_INIT, 8'h00, 1'b0, 6'd0);
		tick_until_idle();
		run_request(OP_CMD, LCD_HOME, 1'b0, 6'd0);
		run_request(OP_CMD, 8'h00, 1'b1, 6'd63);
		run_request(OP_CMD, 8'hFF, 1'b0, 6'd0);
		// characters
		run_request(OP_CHAR, 8'h00, 1'b1, 6'd63);
		run_request(OP_CHAR, 8'hFF, 1'b0, 6'd0);
		// cursor corners and column saturation
		run_request(OP_CURSOR, 8'hFF, 1'b0, 6'd0);
		run_request(OP_CURSOR, 8'h00, 1'b1, 6'd39);
		run_request(OP_CURSOR, 8'h00, 1'b1, 6'd40);
		run_request(OP_CURSOR, 8'h00, 1'b0, 6'd63);
		// clear, then clear, cursor, command and a spare code while busy
		send_request(OP_CLEAR, 8'hFF, 1'b1, 6'd63);
		send_request(OP_CLEAR, 8'h00, 1'b0, 6'd0);
		send_request(OP_CURSOR, 8'h00, 1'b1, 6'd5);
		send_request(OP_CMD, 8'h28, 1'b0, 6'd0);
		send_request(OP_SPARE6, 8'h00, 1'b0, 6'd0);
		tick_until_idle();

		random_traffic(380);
		send_idle_pct  = 68;
		take_stall_pct = 17;
		random_traffic(380);
		send_idle_pct  = 0;
		take_stall_pct = 0;
		random_traffic(380);

		// drain
		req_ch.valid <= 1'b0;
		while (sb.pending_pins.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_pins.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
